### src/ucs_pkg.sv
// Shared types, codes and widths for the USB control endpoint sequencer.
package ucs_pkg;

  // Transfer modes of EP0
  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_READ_DATA  = 2'd1;
  localparam logic [1:0] MODE_READ_WAIT  = 2'd2;
  localparam logic [1:0] MODE_WRITE_STAT = 2'd3;

  // Token and handshake PIDs
  localparam logic [3:0] TOK_SETUP = 4'd13;
  localparam logic [3:0] PID_IN    = 4'd9;
  localparam logic [3:0] PID_OUT   = 4'd1;
  localparam logic [3:0] PID_ACK   = 4'd2;

  // Standard request codes
  localparam logic [7:0] REQ_STATUS     = 8'd0;
  localparam logic [7:0] REQ_SET_ADDR   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC   = 8'd6;
  localparam logic [7:0] REQ_SET_CONFIG = 8'd9;
  localparam logic [7:0] REQ_GET_IF     = 8'd10;

  // Result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SEND     = 3'd1;
  localparam logic [2:0] ACT_ZLP      = 3'd2;
  localparam logic [2:0] ACT_STALL    = 3'd3;
  localparam logic [2:0] ACT_REARM_EP = 3'd4;
  localparam logic [2:0] ACT_IN_DONE  = 3'd5;

  // Device states
  localparam logic [1:0] DEV_DEFAULT    = 2'd0;
  localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
  localparam logic [1:0] DEV_CONFIGURED = 2'd2;

  // Opcode of an input word
  localparam logic OP_TRANSACTION = 1'b0;
  localparam logic OP_BUS_RESET   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PKT_SIZE  = 1'b0;
  localparam logic CFG_SELF_PWR  = 1'b1;

  localparam logic [6:0] PKT_SIZE_RESET = 7'd8;

  localparam int InDataW  = 80;
  localparam int OutDataW = 48;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  endpoint;
    logic        direction_in;
    logic [3:0]  pid;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_length;
    logic        descriptor_found;
    logic [15:0] descriptor_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] chunk_offset;
    logic [6:0]  chunk_count;
    logic        data_toggle;
    logic [7:0]  reply_byte;
    logic        rearm_ep0_out;
    logic [3:0]  out_endpoint;
    logic [6:0]  device_address;
    logic [1:0]  device_state;
  } result_t;

endpackage

### src/usb_control_endpoint_sequencer.sv
// Top level of the USB EP0 control-transfer sequencer.
//
//  Port group   Dir  Contents
//  s_axis_*     in   transaction word or bus reset (tuser = opcode)
//  m_axis_*     out  one result word per input word (tuser = action)
//  cfg_*        in   register write: 0 ep0_packet_size, 1 self_powered
//
//  Each word passes an input register, one stage of decision logic and a
//  result register; one word is taken per cycle while the sink does not stall.
//  The EP0 state advances in the cycle the word moves into the result
//  register. Reset clears all state and sets the packet size to 8.
//  A stalled sink holds the result register; the input register still
//  takes one more word before s_axis_tready drops.
module usb_control_endpoint_sequencer import ucs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // endpoint[3:0], direction_in[4], pid[8:5], request_type[16:9],
  // request_code[24:17], setup_value[40:25], setup_length[56:41],
  // descriptor_found[57], descriptor_length[73:58], zeros[79:74]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // chunk_offset[15:0], chunk_count[22:16], data_toggle[23], reply_byte[31:24],
  // rearm_ep0_out[32], out_endpoint[36:33], device_address[43:37],
  // device_state[45:44], zeros[47:46]
  output logic [OutDataW-1:0] m_axis_tdata,
  // action[2:0]
  output logic [2:0]          m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [6:0]          cfg_wdata_i
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    step;
  result_t res;
  result_t out_res;

  // Unpack the input word
  always_comb begin
    in_item.opcode            = s_axis_tuser;
    in_item.endpoint          = s_axis_tdata[3:0];
    in_item.direction_in      = s_axis_tdata[4];
    in_item.pid               = s_axis_tdata[8:5];
    in_item.request_type      = s_axis_tdata[16:9];
    in_item.request_code      = s_axis_tdata[24:17];
    in_item.setup_value       = s_axis_tdata[40:25];
    in_item.setup_length      = s_axis_tdata[56:41];
    in_item.descriptor_found  = s_axis_tdata[57];
    in_item.descriptor_length = s_axis_tdata[73:58];
  end

  assign step = held_valid && out_free;

  ucs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  ucs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (held_item),
    .res_o       (res)
  );

  ucs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (held_valid),
    .free_o  (out_free),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // Pack the result word
  assign m_axis_tuser = out_res.action;
  assign m_axis_tdata = {2'b00, out_res.device_state, out_res.device_address,
                         out_res.out_endpoint, out_res.rearm_ep0_out,
                         out_res.reply_byte, out_res.data_toggle,
                         out_res.chunk_count, out_res.chunk_offset};

endmodule

### src/ucs_in_reg.sv
// Input register of the sequencer: holds one accepted word until it is processed.
module ucs_in_reg import ucs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Accept when empty or when the held word leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

### src/ucs_ctrl.sv
// EP0 control-transfer state, configuration registers and per-word decision logic.
module ucs_ctrl import ucs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       step_i,
  input  item_t      item_i,
  output result_t    res_o
);

  logic [6:0]  pkt_size_q;
  logic        self_pwr_q;

  logic [1:0]  mode_q, mode_d;
  logic        pend_q, pend_d;
  logic [6:0]  pend_addr_q, pend_addr_d;
  logic [6:0]  addr_q, addr_d;
  logic [1:0]  dev_q, dev_d;
  logic [15:0] sent_q, sent_d;
  logic [15:0] limit_q, limit_d;
  logic        tog_q, tog_d;

  logic        chunk;
  logic        start;
  logic [15:0] st_limit;
  logic [7:0]  st_byte;
  logic [15:0] sent_b;
  logic [15:0] limit_b;
  logic        tog_b;
  logic [15:0] room;
  logic [15:0] pkt16;
  logic        short_pkt;
  logic [6:0]  count;
  logic        do_status;
  result_t     res;

  assign pkt16 = {9'd0, pkt_size_q};

  // Decode the word, then build the chunk and the next state
  always_comb begin
    mode_d      = mode_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    addr_d      = addr_q;
    dev_d       = dev_q;
    sent_d      = sent_q;
    limit_d     = limit_q;
    tog_d       = tog_q;
    res         = '0;
    res.out_endpoint = item_i.endpoint;
    chunk     = 1'b0;
    start     = 1'b0;
    st_limit  = 16'd0;
    st_byte   = 8'd0;
    do_status = 1'b0;

    if (item_i.opcode == OP_BUS_RESET) begin
      mode_d      = MODE_IDLE;
      pend_d      = 1'b0;
      pend_addr_d = 7'd0;
      addr_d      = 7'd0;
      dev_d       = DEV_DEFAULT;
      sent_d      = 16'd0;
      limit_d     = 16'd0;
      tog_d       = 1'b0;
      res.rearm_ep0_out = 1'b1;
      res.out_endpoint  = 4'd0;
    end else if (item_i.endpoint != 4'd0) begin
      res.action = item_i.direction_in ? ACT_IN_DONE : ACT_REARM_EP;
    end else if (item_i.pid == TOK_SETUP) begin
      res.rearm_ep0_out = 1'b1;
      if (item_i.request_type[6:5] == 2'b00) begin
        case (item_i.request_code)
          REQ_GET_DESC: begin
            if (item_i.descriptor_found) begin
              chunk    = 1'b1;
              start    = 1'b1;
              st_limit = (item_i.setup_length < item_i.descriptor_length) ?
                         item_i.setup_length : item_i.descriptor_length;
            end else begin
              res.action = ACT_STALL;
            end
          end
          REQ_SET_ADDR: begin
            pend_addr_d = item_i.setup_value[6:0];
            pend_d      = 1'b1;
            do_status   = 1'b1;
          end
          REQ_SET_CONFIG: begin
            dev_d     = DEV_CONFIGURED;
            do_status = 1'b1;
          end
          REQ_GET_IF: begin
            chunk    = 1'b1;
            start    = 1'b1;
            st_limit = 16'd1;
            st_byte  = 8'd1;
          end
          REQ_STATUS: begin
            chunk    = 1'b1;
            start    = 1'b1;
            st_limit = 16'd1;
            st_byte  = {7'd0, self_pwr_q};
          end
          default: begin
          end
        endcase
      end
    end else if (item_i.pid == PID_IN) begin
      if (mode_q == MODE_READ_DATA) begin
        chunk = 1'b1;
      end else if (mode_q == MODE_WRITE_STAT) begin
        mode_d = MODE_IDLE;
        if (pend_q) begin
          dev_d  = DEV_ADDRESSED;
          addr_d = pend_addr_q;
          pend_d = 1'b0;
        end
      end
    end else if (item_i.pid == PID_ACK) begin
      if (mode_q == MODE_READ_DATA) begin
        chunk = 1'b1;
      end else if (mode_q == MODE_WRITE_STAT) begin
        mode_d = MODE_IDLE;
      end
    end else if (item_i.pid == PID_OUT) begin
      if (mode_q == MODE_READ_WAIT || mode_q == MODE_READ_DATA) begin
        mode_d = MODE_IDLE;
      end
      res.rearm_ep0_out = 1'b1;
    end

    // Zero-length status stage of a write request
    if (do_status) begin
      sent_d          = 16'd0;
      limit_d         = 16'd0;
      tog_d           = 1'b1;
      res.action      = ACT_ZLP;
      res.data_toggle = 1'b1;
      mode_d          = MODE_WRITE_STAT;
    end

    // Chunk of min(packet size, remaining) bytes
    sent_b    = start ? 16'd0 : sent_q;
    limit_b   = start ? st_limit : limit_q;
    tog_b     = start ? 1'b0 : tog_q;
    room      = (sent_b < limit_b) ? (limit_b - sent_b) : 16'd0;
    short_pkt = room < pkt16;
    count     = short_pkt ? room[6:0] : pkt_size_q;
    if (chunk) begin
      res.action       = ACT_SEND;
      res.chunk_offset = sent_b;
      res.chunk_count  = count;
      res.reply_byte   = (count != 7'd0) ? st_byte : 8'd0;
      res.data_toggle  = ~tog_b;
      sent_d           = sent_b + {9'd0, count};
      limit_d          = limit_b;
      tog_d            = ~tog_b;
      // A short chunk that reaches the limit ends the data stage
      mode_d = (short_pkt && (sent_b <= limit_b)) ? MODE_READ_WAIT : MODE_READ_DATA;
    end

    res.device_address = addr_d;
    res.device_state   = dev_d;
  end

  assign res_o = res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_size_q <= PKT_SIZE_RESET;
      self_pwr_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_PKT_SIZE) begin
        pkt_size_q <= cfg_wdata_i;
      end else begin
        self_pwr_q <= cfg_wdata_i[0];
      end
    end
  end

  // Advance the transfer state once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pend_q      <= 1'b0;
      pend_addr_q <= 7'd0;
      addr_q      <= 7'd0;
      dev_q       <= DEV_DEFAULT;
      sent_q      <= 16'd0;
      limit_q     <= 16'd0;
      tog_q       <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      addr_q      <= addr_d;
      dev_q       <= dev_d;
      sent_q      <= sent_d;
      limit_q     <= limit_d;
      tog_q       <= tog_d;
    end
  end

endmodule

### src/ucs_out_reg.sv
// Result register of the sequencer: holds one result word until the sink takes it.
module ucs_out_reg import ucs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  output logic    free_o,
  input  result_t res_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // Free when empty or drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Capture a new result
  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule
